@@ design/wgft_pkg.sv @@
// Constants for the Winograd F(6x6,3x3) filter transform core.
// Holds the fixed-point G matrix and the output field widths; no dependencies.
package wgft_pkg;

   localparam int COEF_W    = 26;
   localparam int COEF_FRAC = 24;
   localparam int ELEM_W    = 36;
   localparam int ROW_W     = 3;
   localparam int NUM_ROWS  = 8;
   localparam int NUM_TAPS  = 3;

   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic [ROW_W-1:0] row_type;

   localparam row_type LAST_ROW = row_type'(NUM_ROWS - 1);

   localparam coef_type C_ONE   = 26'sd16777216;
   localparam coef_type C_ZERO  = 26'sd0;
   localparam coef_type C_2_9   = 26'sd3728270;
   localparam coef_type C_1_90  = 26'sd186414;
   localparam coef_type C_1_45  = 26'sd372827;
   localparam coef_type C_2_45  = 26'sd745654;
   localparam coef_type C_1_180 = 26'sd93207;

   localparam coef_type G_COEF [NUM_ROWS][NUM_TAPS] = '{
      '{C_ONE,   C_ZERO,   C_ZERO},
      '{-C_2_9,  -C_2_9,   -C_2_9},
      '{-C_2_9,  C_2_9,    -C_2_9},
      '{C_1_90,  C_1_45,   C_2_45},
      '{C_1_90,  -C_1_45,  C_2_45},
      '{C_1_45,  C_1_90,   C_1_180},
      '{C_1_45,  -C_1_90,  C_1_180},
      '{C_ZERO,  C_ZERO,   C_ONE}
   };

endpackage

@@ design/winograd_f6x3_filter_transform_core.sv @@
// Winograd F(6x6,3x3) filter transform core: U = G * g * G^T in fixed point.
// Depends on wgft_pkg for the G coefficients and output widths.
//
// A filter is taken when start is high and busy is low. The 8x8 tile leaves
// as eight rows on consecutive cycles, each marked by rsp_valid for one
// cycle. The row sequencer issues one row per cycle into a six-stage
// pipeline; busy drops during the last row so filters follow with no gap.
// The receiver cannot stall the results.
module winograd_f6x3_filter_transform_core #(
   parameter int TAP_WIDTH = 16,
   parameter int FRAC_BITS = 20
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [TAP_WIDTH-1:0]           req_tap_r0c0,
   input  logic signed [TAP_WIDTH-1:0]           req_tap_r0c1,
   input  logic signed [TAP_WIDTH-1:0]           req_tap_r0c2,
   input  logic signed [TAP_WIDTH-1:0]           req_tap_r1c0,
   input  logic signed [TAP_WIDTH-1:0]           req_tap_r1c1,
   input  logic signed [TAP_WIDTH-1:0]           req_tap_r1c2,
   input  logic signed [TAP_WIDTH-1:0]           req_tap_r2c0,
   input  logic signed [TAP_WIDTH-1:0]           req_tap_r2c1,
   input  logic signed [TAP_WIDTH-1:0]           req_tap_r2c2,
   output logic                                  rsp_valid,
   output logic [wgft_pkg::ROW_W-1:0]            rsp_row_index,
   output logic signed [wgft_pkg::ELEM_W-1:0]    rsp_elem0,
   output logic signed [wgft_pkg::ELEM_W-1:0]    rsp_elem1,
   output logic signed [wgft_pkg::ELEM_W-1:0]    rsp_elem2,
   output logic signed [wgft_pkg::ELEM_W-1:0]    rsp_elem3,
   output logic signed [wgft_pkg::ELEM_W-1:0]    rsp_elem4,
   output logic signed [wgft_pkg::ELEM_W-1:0]    rsp_elem5,
   output logic signed [wgft_pkg::ELEM_W-1:0]    rsp_elem6,
   output logic signed [wgft_pkg::ELEM_W-1:0]    rsp_elem7,
   output logic                                  rsp_last_row
);
   import wgft_pkg::*;

   localparam int P1_W    = COEF_W + TAP_WIDTH;
   localparam int T_W     = P1_W + 2;
   localparam int TLO_W   = T_W / 2;
   localparam int THI_W   = T_W - TLO_W;
   localparam int PLO_W   = TLO_W + 1 + COEF_W;
   localparam int PHI_W   = THI_W + COEF_W;
   localparam int ACC_W   = T_W + COEF_W + 2;
   localparam int SHIFT   = 2 * COEF_FRAC - FRAC_BITS;
   localparam int SUM_W   = (ACC_W > SHIFT + ELEM_W) ? ACC_W : SHIFT + ELEM_W;
   localparam int NUM_STG = 6;
   localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (SHIFT - 1);

   logic                        accept;
   logic                        active_ff, active_in;
   row_type                     row_ff, row_in;
   logic signed [TAP_WIDTH-1:0] tap_in [NUM_TAPS][NUM_TAPS];
   logic signed [TAP_WIDTH-1:0] tap_ff [NUM_TAPS][NUM_TAPS];

   logic                        vld_ff [NUM_STG];
   logic                        vld_in [NUM_STG];
   row_type                     stg_row_ff [NUM_STG];
   row_type                     stg_row_in [NUM_STG];

   logic signed [P1_W-1:0]      p1_in  [NUM_TAPS][NUM_TAPS];
   logic signed [P1_W-1:0]      p1_ff  [NUM_TAPS][NUM_TAPS];
   logic signed [T_W-1:0]       t2_in  [NUM_TAPS];
   logic signed [T_W-1:0]       t2_ff  [NUM_TAPS];
   logic signed [PLO_W-1:0]     lo3_in [NUM_ROWS][NUM_TAPS];
   logic signed [PLO_W-1:0]     lo3_ff [NUM_ROWS][NUM_TAPS];
   logic signed [PHI_W-1:0]     hi3_in [NUM_ROWS][NUM_TAPS];
   logic signed [PHI_W-1:0]     hi3_ff [NUM_ROWS][NUM_TAPS];
   logic signed [SUM_W-1:0]     p4_in  [NUM_ROWS][NUM_TAPS];
   logic signed [SUM_W-1:0]     p4_ff  [NUM_ROWS][NUM_TAPS];
   logic signed [SUM_W-1:0]     s5_in  [NUM_ROWS];
   logic signed [SUM_W-1:0]     s5_ff  [NUM_ROWS];
   logic signed [ELEM_W-1:0]    elem_in [NUM_ROWS];
   logic signed [ELEM_W-1:0]    elem_ff [NUM_ROWS];

   assign busy   = active_ff && (row_ff != LAST_ROW);
   assign accept = start && !busy;

   // row sequencer
   always_comb begin
      tap_in[0][0] = req_tap_r0c0;
      tap_in[0][1] = req_tap_r0c1;
      tap_in[0][2] = req_tap_r0c2;
      tap_in[1][0] = req_tap_r1c0;
      tap_in[1][1] = req_tap_r1c1;
      tap_in[1][2] = req_tap_r1c2;
      tap_in[2][0] = req_tap_r2c0;
      tap_in[2][1] = req_tap_r2c1;
      tap_in[2][2] = req_tap_r2c2;
      active_in = active_ff;
      row_in    = row_ff;
      priority if (accept) begin
         active_in = 1'b1;
         row_in    = '0;
      end else if (active_ff) begin
         row_in = row_ff + row_type'(1);
         if (row_ff == LAST_ROW) begin
            active_in = 1'b0;
         end
      end else begin
         active_in = 1'b0;
      end
   end

   // pipeline datapath
   always_comb begin
      vld_in[0]     = active_ff;
      stg_row_in[0] = row_ff;
      for (int s = 1; s < NUM_STG; s++) begin
         vld_in[s]     = vld_ff[s-1];
         stg_row_in[s] = stg_row_ff[s-1];
      end
      for (int k = 0; k < NUM_TAPS; k++) begin
         for (int l = 0; l < NUM_TAPS; l++) begin
            p1_in[k][l] = G_COEF[row_ff][k] * tap_ff[k][l];
         end
      end
      for (int l = 0; l < NUM_TAPS; l++) begin
         t2_in[l] = T_W'(p1_ff[0][l]) + T_W'(p1_ff[1][l]) + T_W'(p1_ff[2][l]);
      end
      for (int j = 0; j < NUM_ROWS; j++) begin
         for (int l = 0; l < NUM_TAPS; l++) begin
            lo3_in[j][l] = $signed({1'b0, t2_ff[l][TLO_W-1:0]}) * G_COEF[j][l];
            hi3_in[j][l] = $signed(t2_ff[l][T_W-1:TLO_W]) * G_COEF[j][l];
            p4_in[j][l]  = (SUM_W'(hi3_ff[j][l]) <<< TLO_W) + SUM_W'(lo3_ff[j][l]);
         end
         s5_in[j]   = p4_ff[j][0] + p4_ff[j][1] + p4_ff[j][2] + HALF;
         elem_in[j] = s5_ff[j][SHIFT+ELEM_W-1:SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         row_ff    <= '0;
         for (int s = 0; s < NUM_STG; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else begin
         active_ff <= active_in;
         row_ff    <= row_in;
         for (int s = 0; s < NUM_STG; s++) begin
            vld_ff[s] <= vld_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tap_ff <= tap_in;
      end
      stg_row_ff <= stg_row_in;
      p1_ff      <= p1_in;
      t2_ff      <= t2_in;
      lo3_ff     <= lo3_in;
      hi3_ff     <= hi3_in;
      p4_ff      <= p4_in;
      s5_ff      <= s5_in;
      elem_ff    <= elem_in;
   end

   assign rsp_valid     = vld_ff[NUM_STG-1];
   assign rsp_row_index = stg_row_ff[NUM_STG-1];
   assign rsp_last_row  = (stg_row_ff[NUM_STG-1] == LAST_ROW);
   assign rsp_elem0     = elem_ff[0];
   assign rsp_elem1     = elem_ff[1];
   assign rsp_elem2     = elem_ff[2];
   assign rsp_elem3     = elem_ff[3];
   assign rsp_elem4     = elem_ff[4];
   assign rsp_elem5     = elem_ff[5];
   assign rsp_elem6     = elem_ff[6];
   assign rsp_elem7     = elem_ff[7];

endmodule
